// ===== sv/kht_pkg.sv =====
// Shared constants, request codes and queue item type for the keyed handle table.
package kht_pkg;

  localparam int KHT_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int HDL_W       = 32;
  localparam int RANGE_W     = 32;

  localparam logic [RANGE_W-1:0] KEY_RANGE_RST = 32'd65536;

  typedef logic [1:0] op_t;

  localparam op_t OP_REG   = 2'd0;
  localparam op_t OP_UNREG = 2'd1;
  localparam op_t OP_LOOK  = 2'd2;
  localparam op_t OP_NEXT  = 2'd3;

  typedef struct packed {
    op_t              op;
    logic             needs_scan;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
  } kht_item_t;

endpackage

// ===== sv/kht_if.sv =====
// Channel interfaces: request, response and configuration write.
interface kht_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [kht_pkg::KEY_W-1:0] key;
  logic [kht_pkg::HDL_W-1:0] handle;

  modport source (output valid, output req_type, output key, output handle, input ready);
  modport sink   (input valid, input req_type, input key, input handle, output ready);
endinterface

interface kht_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [kht_pkg::HDL_W-1:0] old_handle;
  logic                      table_full;
  logic [kht_pkg::KEY_W-1:0] issued_key;

  modport source (output valid, output found, output old_handle, output table_full,
                  output issued_key, input ready);
  modport sink   (input valid, input found, input old_handle, input table_full,
                  input issued_key, output ready);
endinterface

interface kht_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kht_pkg::RANGE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/kht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== sv/kht_front.sv =====
// Front end: accepts request items, classifies them and queues them for the back end.
module kht_front (
  input  logic               clk,
  input  logic               rst_n,
  kht_req_if.sink            in_ch,
  output logic               q_valid,
  output kht_pkg::kht_item_t q_item,
  input  logic               q_pop
);
  import kht_pkg::*;

  kht_item_t  q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] n_r;
  kht_item_t  cls;
  logic       push;
  logic       pop;

  // Next-key items need no key, only register items carry a handle.
  always_comb begin
    cls.op         = op_t'(in_ch.req_type);
    cls.needs_scan = (in_ch.req_type != OP_NEXT);
    cls.key        = (in_ch.req_type == OP_NEXT) ? '0 : in_ch.key;
    cls.handle     = (in_ch.req_type == OP_REG) ? in_ch.handle : '0;
  end

  assign in_ch.ready = (n_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (n_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_item      = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      n_r <= n_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/kht_back.sv =====
// Back end: scans the slot RAM, updates the table and key counter, holds the result.
module kht_back #(
  parameter int TABLE_ENTRIES = kht_pkg::KHT_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  kht_pkg::kht_item_t          q_item,
  output logic                        q_pop,
  input  logic [kht_pkg::RANGE_W-1:0] key_range,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [kht_pkg::HDL_W-1:0]   out_old_handle,
  output logic                        out_table_full,
  output logic [kht_pkg::KEY_W-1:0]   out_issued_key
);
  import kht_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = KEY_W + HDL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]             st_r;
  kht_item_t              it_r;
  logic [CW-1:0]          cnt_r;
  logic                   pend_r;
  logic                   pv_r;
  logic [IW-1:0]          pidx_r;
  logic                   hit_r;
  logic [IW-1:0]          slot_r;
  logic [HDL_W-1:0]       old_r;
  logic                   fh_r;
  logic [IW-1:0]          fslot_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]       ctr_r;
  logic [KEY_W-1:0]       ctr_nxt;
  logic [KEY_W:0]         ctr_inc;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [HDL_W-1:0]       out_old_r;
  logic                   out_full_r;
  logic [KEY_W-1:0]       out_issued_r;

  logic [IW-1:0]          ridx;
  logic                   issue;
  logic [SW-1:0]          rdata;
  logic                   match;
  logic                   scan_done;
  logic                   wb_go;
  logic                   we;
  logic [IW-1:0]          waddr;

  assign ridx      = cnt_r[IW-1:0];
  assign issue     = (cnt_r != CW'(TABLE_ENTRIES));
  assign match     = pend_r && pv_r && (rdata[SW-1:HDL_W] == it_r.key);
  assign scan_done = !issue && !pend_r;
  assign wb_go     = (st_r == ST_WB) && (!out_valid_r || out_ready);
  assign q_pop     = (st_r == ST_IDLE) && q_valid;

  assign ctr_inc = {1'b0, ctr_r} + {{KEY_W{1'b0}}, 1'b1};
  assign ctr_nxt = (ctr_inc >= {1'b0, key_range}) ? '0 : ctr_inc[KEY_W-1:0];

  // Register writes go to the matched slot, else to the lowest free slot.
  assign we    = wb_go && (it_r.op == OP_REG) && (hit_r || fh_r);
  assign waddr = hit_r ? slot_r : fslot_r;

  kht_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({it_r.key, it_r.handle}),
    .raddr (ridx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r <= q_item;
    end
    if (st_r == ST_SCAN) begin
      pidx_r <= ridx;
      pv_r   <= valid_r[ridx];
      if (match) begin
        slot_r <= pidx_r;
        old_r  <= rdata[HDL_W-1:0];
      end
      if (issue && !fh_r && !valid_r[ridx]) begin
        fslot_r <= ridx;
      end
    end
    if (wb_go) begin
      case (it_r.op)
        OP_REG: begin
          out_found_r  <= hit_r;
          out_old_r    <= hit_r ? old_r : '0;
          out_full_r   <= !hit_r && !fh_r;
          out_issued_r <= '0;
        end
        OP_UNREG, OP_LOOK: begin
          out_found_r  <= hit_r;
          out_old_r    <= hit_r ? old_r : '0;
          out_full_r   <= 1'b0;
          out_issued_r <= '0;
        end
        OP_NEXT: begin
          out_found_r  <= 1'b0;
          out_old_r    <= '0;
          out_full_r   <= 1'b0;
          out_issued_r <= ctr_r;
        end
        default: begin
          out_found_r  <= 1'b0;
          out_old_r    <= '0;
          out_full_r   <= 1'b0;
          out_issued_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      fh_r        <= 1'b0;
      valid_r     <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            cnt_r  <= '0;
            pend_r <= 1'b0;
            hit_r  <= 1'b0;
            fh_r   <= 1'b0;
            st_r   <= q_item.needs_scan ? ST_SCAN : ST_WB;
          end
        end
        ST_SCAN: begin
          // Read one slot a cycle; compare the slot read in the cycle before.
          pend_r <= issue;
          if (issue) begin
            cnt_r <= cnt_r + {{(CW-1){1'b0}}, 1'b1};
            if (!valid_r[ridx]) begin
              fh_r <= 1'b1;
            end
          end
          if (match) begin
            hit_r <= 1'b1;
            st_r  <= ST_WB;
          end else if (scan_done) begin
            st_r <= ST_WB;
          end
        end
        ST_WB: begin
          if (wb_go) begin
            st_r <= ST_IDLE;
            case (it_r.op)
              OP_REG: begin
                if (!hit_r && fh_r) begin
                  valid_r[fslot_r] <= 1'b1;
                end
              end
              OP_UNREG: begin
                if (hit_r) begin
                  valid_r[slot_r] <= 1'b0;
                end
              end
              OP_NEXT: begin
                ctr_r <= ctr_nxt;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_old_handle = out_old_r;
  assign out_table_full = out_full_r;
  assign out_issued_key = out_issued_r;

endmodule

// ===== sv/keyed_handle_table.sv =====
// Top level of the keyed handle table: front end, request queue, back end and key range register.
// Each request item gives exactly one response item. The front end queues up to two items
// while the back end works. A register, unregister or lookup item reads the slot RAM one slot
// per cycle through its single read port, from slot 0 upward, and its scan ends early when a
// slot matches; a next-key item skips the scan. The response sits in an output register, so
// the back end moves on to the next item while it waits to be taken, but holds its next
// response in write-back until the last one is taken. The configuration channel is always
// ready and writes key_range (reset 65536) at its handshake.
module keyed_handle_table #(
  parameter int TABLE_ENTRIES = kht_pkg::KHT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  kht_req_if.sink   in_ch,
  kht_rsp_if.source out_ch,
  kht_cfg_if.sink   cfg_ch
);
  import kht_pkg::*;

  logic               q_valid;
  kht_item_t          q_item;
  logic               q_pop;
  logic [RANGE_W-1:0] key_range_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_range_r <= KEY_RANGE_RST;
    end else if (cfg_ch.valid) begin
      key_range_r <= cfg_ch.data;
    end
  end

  kht_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  kht_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .key_range      (key_range_r),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_found      (out_ch.found),
    .out_old_handle (out_ch.old_handle),
    .out_table_full (out_ch.table_full),
    .out_issued_key (out_ch.issued_key)
  );

endmodule

// ===== sv/kht_checker.sv =====
// Port-level checks for the keyed handle table, bound to the top level.
module kht_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_found,
  input logic [kht_pkg::HDL_W-1:0] out_old_handle,
  input logic                      out_table_full,
  input logic [kht_pkg::KEY_W-1:0] out_issued_key
);

  // A stalled response holds its found flag and old handle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_old_handle) && $stable(out_found))
    else $error("response changed while stalled");

  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_found && (out_old_handle == '0))
    else $error("table_full with a match or a handle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_old_handle == '0))
    else $error("nonzero handle without a match");

  a_key_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_issued_key != '0) |-> !out_found && !out_table_full)
    else $error("issued key mixed with table result");

endmodule

bind keyed_handle_table kht_checker u_kht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found      (out_ch.found),
  .out_old_handle (out_ch.old_handle),
  .out_table_full (out_ch.table_full),
  .out_issued_key (out_ch.issued_key)
);
